// ===== design/tlvsdnv_pkg.sv =====
// ----------------------------------------------------------------------------
// tlvsdnv_pkg
// Shared types and codes for the TLV parser with SDNV-coded lengths.
// ----------------------------------------------------------------------------
`default_nettype none

package tlvsdnv_pkg;

   localparam int BYTE_W    = 8;
   localparam int OUT_LEN_W = 32;
   localparam int CFG_W     = 32;
   localparam int ROLE_W    = 2;
   localparam int ERR_W     = 3;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [ROLE_W-1:0] ROLE_TYPE   = 2'd0;
   localparam logic [ROLE_W-1:0] ROLE_LENGTH = 2'd1;
   localparam logic [ROLE_W-1:0] ROLE_VALUE  = 2'd2;
   localparam logic [ROLE_W-1:0] ROLE_IGNORE = 2'd3;

   localparam logic [ERR_W-1:0] ERR_NONE       = 3'd0;
   localparam logic [ERR_W-1:0] ERR_END_TYPE   = 3'd1;
   localparam logic [ERR_W-1:0] ERR_END_LENGTH = 3'd2;
   localparam logic [ERR_W-1:0] ERR_END_VALUE  = 3'd3;
   localparam logic [ERR_W-1:0] ERR_OVER_LIMIT = 3'd4;

   localparam int TDATA_FIELDS_W = BYTE_W + BYTE_W + OUT_LEN_W + OUT_LEN_W + 1 + ERR_W;
   localparam int RSP_TDATA_W    = ((TDATA_FIELDS_W + 7) / 8) * 8;

   typedef struct packed {
      logic [ROLE_W-1:0]    byte_role;
      logic [BYTE_W-1:0]    item_kind;
      logic [BYTE_W-1:0]    value_byte;
      logic [OUT_LEN_W-1:0] value_index;
      logic [OUT_LEN_W-1:0] value_len;
      logic                 item_end;
      logic                 buffer_end;
      logic [ERR_W-1:0]     error_code;
   } result_type;

endpackage

`default_nettype wire

// ===== design/tlvsdnv_parse.sv =====
// ----------------------------------------------------------------------------
// tlvsdnv_parse
// Front end: takes one buffer byte per transfer, tracks the TLV phase,
// decodes the SDNV length and tags the byte.
// ----------------------------------------------------------------------------
`default_nettype none

module tlvsdnv_parse
   import tlvsdnv_pkg::*;
#(
   parameter int LEN_WIDTH = 32
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              accept,
   input  wire logic [BYTE_W-1:0] data_byte,
   input  wire logic              last_byte,
   input  wire logic [CFG_W-1:0]  max_len,
   output result_type             result
);

   localparam int CW = (LEN_WIDTH > OUT_LEN_W) ? LEN_WIDTH : OUT_LEN_W;

   localparam logic [1:0] PH_TYPE   = 2'd0;
   localparam logic [1:0] PH_LENGTH = 2'd1;
   localparam logic [1:0] PH_VALUE  = 2'd2;

   logic [1:0]           phase_ff, phase_in;
   logic [BYTE_W-1:0]    type_ff, type_in;
   logic [LEN_WIDTH-1:0] acc_ff, acc_in;
   logic [LEN_WIDTH-1:0] rem_ff, rem_in;
   logic [LEN_WIDTH-1:0] cnt_ff, cnt_in;
   logic                 err_ff, err_in;

   logic [LEN_WIDTH-1:0] acc_shift;
   logic [CW-1:0]        acc_shift_ext;
   logic [CW-1:0]        acc_ext;
   logic [CW-1:0]        cnt_ext;

   assign acc_shift     = {acc_ff[LEN_WIDTH-8:0], data_byte[6:0]};
   assign acc_shift_ext = CW'(acc_shift);
   assign acc_ext       = CW'(acc_ff);
   assign cnt_ext       = CW'(cnt_ff);

   always_comb begin
      phase_in = phase_ff;
      type_in  = type_ff;
      acc_in   = acc_ff;
      rem_in   = rem_ff;
      cnt_in   = cnt_ff;
      err_in   = err_ff;

      result.byte_role    = ROLE_IGNORE;
      result.item_kind    = '0;
      result.value_byte   = '0;
      result.value_index  = '0;
      result.value_len    = '0;
      result.item_end     = 1'b0;
      result.buffer_end   = last_byte;
      result.error_code   = ERR_NONE;

      if (!err_ff) begin
         unique case (phase_ff)
            PH_TYPE: begin
               result.byte_role = ROLE_TYPE;
               result.item_kind = data_byte;
               type_in          = data_byte;
               acc_in           = '0;
               if (last_byte) begin
                  result.error_code = ERR_END_TYPE;
               end else begin
                  phase_in = PH_LENGTH;
               end
            end
            PH_LENGTH: begin
               result.byte_role = ROLE_LENGTH;
               result.item_kind = type_ff;
               if (acc_ff[LEN_WIDTH-1 -: 7] != 7'd0) begin
                  result.error_code = ERR_OVER_LIMIT;
               end else begin
                  acc_in = acc_shift;
                  if (data_byte[7]) begin
                     if (last_byte) begin
                        result.error_code = ERR_END_LENGTH;
                     end
                  end else if (acc_shift_ext > CW'(max_len)) begin
                     result.error_code = ERR_OVER_LIMIT;
                  end else begin
                     result.value_len = acc_shift_ext[OUT_LEN_W-1:0];
                     if (acc_shift == '0) begin
                        result.item_end = 1'b1;
                        phase_in        = PH_TYPE;
                     end else if (last_byte) begin
                        result.error_code = ERR_END_VALUE;
                     end else begin
                        rem_in   = acc_shift;
                        cnt_in   = '0;
                        phase_in = PH_VALUE;
                     end
                  end
               end
            end
            default: begin
               result.byte_role    = ROLE_VALUE;
               result.item_kind    = type_ff;
               result.value_byte   = data_byte;
               result.value_index  = cnt_ext[OUT_LEN_W-1:0];
               result.value_len    = acc_ext[OUT_LEN_W-1:0];
               cnt_in = cnt_ff + LEN_WIDTH'(1);
               rem_in = rem_ff - LEN_WIDTH'(1);
               if (rem_ff == LEN_WIDTH'(1)) begin
                  result.item_end = 1'b1;
                  phase_in        = PH_TYPE;
               end else if (last_byte) begin
                  result.error_code = ERR_END_VALUE;
               end
            end
         endcase
      end

      if (result.error_code != ERR_NONE) begin
         err_in = 1'b1;
      end
      if (last_byte) begin
         phase_in = PH_TYPE;
         acc_in   = '0;
         rem_in   = '0;
         cnt_in   = '0;
         err_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_TYPE;
         type_ff  <= '0;
         acc_ff   <= '0;
         rem_ff   <= '0;
         cnt_ff   <= '0;
         err_ff   <= 1'b0;
      end else if (accept) begin
         phase_ff <= phase_in;
         type_ff  <= type_in;
         acc_ff   <= acc_in;
         rem_ff   <= rem_in;
         cnt_ff   <= cnt_in;
         err_ff   <= err_in;
      end
   end

endmodule

`default_nettype wire

// ===== design/tlvsdnv_queue.sv =====
// ----------------------------------------------------------------------------
// tlvsdnv_queue
// Short register queue of tagged results between front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none

module tlvsdnv_queue
   import tlvsdnv_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       push,
   input  wire result_type push_data,
   output logic            full,
   input  wire logic       pop,
   output logic            not_empty,
   output result_type      head
);

   localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   result_type       slot_ff [QUEUE_DEPTH];
   logic [PW-1:0]    wr_ff, wr_in;
   logic [PW-1:0]    rd_ff, rd_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full      = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = slot_ff[rd_ff];

   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (push) begin
         wr_in = (wr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ff + PW'(1);
      end
      if (pop) begin
         rd_in = (rd_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ff + PW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ===== design/tlvsdnv_out.sv =====
// ----------------------------------------------------------------------------
// tlvsdnv_out
// Back end: output register that drains the queue and packs the result
// stream.
// ----------------------------------------------------------------------------
`default_nettype none

module tlvsdnv_out
   import tlvsdnv_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   q_not_empty,
   input  wire result_type             q_head,
   output logic                        q_pop,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0]      rsp_tdata,
   output logic [ROLE_W-1:0]           rsp_tuser,
   output logic                        rsp_tlast
);

   logic       valid_ff;
   result_type res_ff;

   assign q_pop = q_not_empty && (!valid_ff || rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (q_pop) begin
         valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         res_ff <= q_head;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tuser  = res_ff.byte_role;
   assign rsp_tlast  = res_ff.buffer_end;
   assign rsp_tdata  = RSP_TDATA_W'({res_ff.error_code, res_ff.item_end,
                                    res_ff.value_len, res_ff.value_index,
                                    res_ff.value_byte, res_ff.item_kind});

endmodule

`default_nettype wire

// ===== design/tlv_sdnv_length_parser.sv =====
// ----------------------------------------------------------------------------
// tlv_sdnv_length_parser
// Byte-serial TLV buffer parser with SDNV-coded lengths and a length limit.
// ----------------------------------------------------------------------------
//   channel  dir  handshake          payload
//   req_     in   tvalid/tready      tdata = data_byte, tlast = last_byte
//   rsp_     out  tvalid/tready      tdata = tag fields, tuser = byte_role,
//                                    tlast = buffer_end
//   csr_     in   valid/ready        data = max_field_length
//
// One byte per cycle while the queue has room; a result passes through a queue
// slot, then the output register, before its transfer.
// The parse state advances once per accepted byte, which sets the rate.
// A two-entry queue plus the output register absorb rsp_ backpressure;
// req_tready drops only when the queue is full.
// Reset is synchronous; the limit register resets to all ones.
// ----------------------------------------------------------------------------
`default_nettype none

module tlv_sdnv_length_parser
   import tlvsdnv_pkg::*;
#(
   parameter int LEN_WIDTH = 32
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [BYTE_W-1:0]      req_tdata,   // [7:0] data_byte
   input  wire logic                   req_tlast,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   // [7:0] item_kind, [15:8] value_byte, [47:16] value_index,
   // [79:48] value_len, [80] item_end, [83:81] error_code, rest zero
   output logic [RSP_TDATA_W-1:0]      rsp_tdata,
   output logic [ROLE_W-1:0]           rsp_tuser,   // [1:0] byte_role
   output logic                        rsp_tlast,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CFG_W-1:0]       csr_data     // [31:0] max_field_length
);

   logic [CFG_W-1:0] max_len_ff;
   logic             accept;
   logic             q_full;
   logic             q_not_empty;
   logic             q_pop;
   result_type       parsed;
   result_type       q_head;

   assign csr_ready  = 1'b1;
   assign req_tready = !q_full;
   assign accept     = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= '1;
      end else if (csr_valid && csr_ready) begin
         max_len_ff <= csr_data;
      end
   end

   tlvsdnv_parse #(
      .LEN_WIDTH (LEN_WIDTH)
   ) u_parse (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .data_byte (req_tdata),
      .last_byte (req_tlast),
      .max_len   (max_len_ff),
      .result    (parsed)
   );

   tlvsdnv_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_data (parsed),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .head      (q_head)
   );

   tlvsdnv_out u_out (
      .clock       (clock),
      .reset       (reset),
      .q_not_empty (q_not_empty),
      .q_head      (q_head),
      .q_pop       (q_pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast)
   );

endmodule

`default_nettype wire

// ===== design/tlvsdnv_check.sv =====
// ----------------------------------------------------------------------------
// tlvsdnv_check
// Port-level checks for the TLV parser, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module tlvsdnv_check
   import tlvsdnv_pkg::*;
(
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   rsp_tvalid,
   input wire logic                   rsp_tready,
   input wire logic [RSP_TDATA_W-1:0] rsp_tdata,
   input wire logic [ROLE_W-1:0]      rsp_tuser,
   input wire logic                   rsp_tlast
);

   localparam int ERR_LSB = 2 * BYTE_W + 2 * OUT_LEN_W + 1;
   localparam int IEND_BIT = 2 * BYTE_W + 2 * OUT_LEN_W;

   logic [ERR_W-1:0] err;
   logic             iend;

   assign err  = rsp_tdata[ERR_LSB +: ERR_W];
   assign iend = rsp_tdata[IEND_BIT];

   a_reset_idle: assert property (@(posedge clock) $past(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result transfer changed");

   a_end_err_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (err == ERR_END_TYPE || err == ERR_END_LENGTH ||
                     err == ERR_END_VALUE) |-> rsp_tlast)
      else $error("buffer end error without buffer end");

   a_ignored_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == ROLE_IGNORE |-> err == ERR_NONE && !iend)
      else $error("ignored byte carries error or item end");

   a_item_end_role: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && iend |-> rsp_tuser == ROLE_LENGTH || rsp_tuser == ROLE_VALUE)
      else $error("item end on type or ignored byte");

endmodule

bind tlv_sdnv_length_parser tlvsdnv_check u_check (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the TLV parser with SDNV-coded lengths. A driver
// streams buffers into req_, a monitor takes every rsp_ transfer and compares
// it field by field against a cycle-free parse of the same bytes. The length
// limit register is swept over its extremes between phases, and both sides
// of the stream idle at random.
// ----------------------------------------------------------------------------
module tb
   import tlvsdnv_pkg::*;
();

   localparam int LEN_W       = 32;
   localparam int CYCLE_LIMIT = 500000;
   localparam int BYTES_PER_PHASE = 315;
   localparam int NUM_PHASES  = 6;

   typedef enum logic [1:0] {EXPECT_TYPE, EXPECT_LENGTH, EXPECT_VALUE} parse_phase_type;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
      logic       drain;
   } stream_byte_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [BYTE_W-1:0]      req_tdata = '0;
   logic                   req_tlast = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic [ROLE_W-1:0]      rsp_tuser;
   logic                   rsp_tlast;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CFG_W-1:0]       csr_data = '0;

   // parser shadow state
   parse_phase_type        phase;
   logic [7:0]             cur_type;
   logic [LEN_W-1:0]       len_acc;
   logic [LEN_W-1:0]       remaining;
   logic [LEN_W-1:0]       value_count;
   logic                   err_latched;
   logic [CFG_W-1:0]       len_limit;

   stream_byte_type        pending_bytes[$];
   result_type             expected_tags[$];
   logic [7:0]             frame_bytes[$];
   int                     queued_bytes = 0;
   int                     error_count = 0;
   int                     result_count = 0;
   int unsigned            cycle_count = 0;
   int                     req_idle_max = 13;
   int                     rsp_idle_max = 13;
   int                     req_gap = 0;
   int                     rsp_wait = 0;
   logic                   send_now;
   stream_byte_type        next_byte;
   result_type             seen_tag;

   tlv_sdnv_length_parser #(.LEN_WIDTH(LEN_W)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic void restart_parse();
      phase       = EXPECT_TYPE;
      len_acc     = '0;
      remaining   = '0;
      value_count = '0;
      err_latched = 1'b0;
   endfunction

   function automatic result_type parse_byte(input logic [7:0] b, input logic last);
      result_type       r;
      logic [ERR_W-1:0] err;
      r            = '0;
      r.byte_role  = ROLE_IGNORE;
      r.buffer_end = last;
      err          = ERR_NONE;
      if (!err_latched) begin
         if (phase == EXPECT_TYPE) begin
            r.byte_role = ROLE_TYPE;
            cur_type    = b;
            r.item_kind = b;
            len_acc     = '0;
            if (last) err = ERR_END_TYPE;
            else phase = EXPECT_LENGTH;
         end else if (phase == EXPECT_LENGTH) begin
            r.byte_role = ROLE_LENGTH;
            r.item_kind = cur_type;
            if ((len_acc >> (LEN_W - 7)) != 0) begin
               err = ERR_OVER_LIMIT;
            end else begin
               len_acc = {len_acc[LEN_W-8:0], b[6:0]};
               if (b[7]) begin
                  if (last) err = ERR_END_LENGTH;
               end else if (len_acc > len_limit) begin
                  err = ERR_OVER_LIMIT;
               end else begin
                  r.value_len = len_acc;
                  if (len_acc == 0) begin
                     r.item_end = 1'b1;
                     phase      = EXPECT_TYPE;
                  end else if (last) begin
                     err = ERR_END_VALUE;
                  end else begin
                     remaining   = len_acc;
                     value_count = '0;
                     phase       = EXPECT_VALUE;
                  end
               end
            end
         end else begin
            r.byte_role    = ROLE_VALUE;
            r.item_kind    = cur_type;
            r.value_byte   = b;
            r.value_index  = value_count;
            r.value_len    = len_acc;
            value_count    = value_count + 1'b1;
            remaining      = remaining - 1'b1;
            if (remaining == 0) begin
               r.item_end = 1'b1;
               phase      = EXPECT_TYPE;
            end else if (last) begin
               err = ERR_END_VALUE;
            end
         end
      end
      if (err != ERR_NONE) err_latched = 1'b1;
      if (last) restart_parse();
      r.error_code = err;
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      error_count++;
      $display("tb: result %0d %s: got %0h, want %0h", result_count, what, got, want);
   endtask

   task automatic check_result(input result_type got, input logic [3:0] pad);
      result_type want;
      if (expected_tags.size() == 0) begin
         report_mismatch("unexpected transfer", 0, 0);
         return;
      end
      want = expected_tags.pop_front();
      if (got.byte_role != want.byte_role)
         report_mismatch("byte_role", 32'(got.byte_role), 32'(want.byte_role));
      if (got.item_kind != want.item_kind)
         report_mismatch("item_kind", 32'(got.item_kind), 32'(want.item_kind));
      if (got.value_byte != want.value_byte)
         report_mismatch("value_byte", 32'(got.value_byte), 32'(want.value_byte));
      if (got.value_index != want.value_index)
         report_mismatch("value_index", got.value_index, want.value_index);
      if (got.value_len != want.value_len)
         report_mismatch("value_len", got.value_len, want.value_len);
      if (got.item_end != want.item_end)
         report_mismatch("item_end", 32'(got.item_end), 32'(want.item_end));
      if (got.buffer_end != want.buffer_end)
         report_mismatch("buffer_end", 32'(got.buffer_end), 32'(want.buffer_end));
      if (got.error_code != want.error_code)
         report_mismatch("error_code", 32'(got.error_code), 32'(want.error_code));
      if (pad != 0)
         report_mismatch("tdata padding", 32'(pad), 0);
   endtask

   // sender: one transfer per free slot, random gap after each transfer
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tlast  <= 1'b0;
         req_tdata  <= '0;
         req_gap     = 0;
      end else begin
         send_now = 1'b0;
         if (req_tvalid && req_tready) begin
            expected_tags.push_back(parse_byte(req_tdata, req_tlast));
            req_gap = $urandom_range(0, req_idle_max);
         end
         if (!req_tvalid || req_tready) begin
            if (req_gap > 0)
               req_gap = req_gap - 1;
            else if (pending_bytes.size() > 0 &&
                     !(pending_bytes[0].drain && (expected_tags.size() != 0 || req_tvalid)))
               send_now = 1'b1;
         end
         if (send_now) begin
            next_byte = pending_bytes.pop_front();
            req_tdata  <= next_byte.data;
            req_tlast  <= next_byte.last;
            req_tvalid <= 1'b1;
         end else if (!req_tvalid || req_tready) begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // receiver: check each transfer, then stall a random number of cycles
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_wait    = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            seen_tag.byte_role    = rsp_tuser;
            seen_tag.item_kind    = rsp_tdata[7:0];
            seen_tag.value_byte   = rsp_tdata[15:8];
            seen_tag.value_index  = rsp_tdata[47:16];
            seen_tag.value_len    = rsp_tdata[79:48];
            seen_tag.item_end     = rsp_tdata[80];
            seen_tag.error_code   = rsp_tdata[83:81];
            seen_tag.buffer_end   = rsp_tlast;
            check_result(seen_tag, 4'(rsp_tdata[RSP_TDATA_W-1:TDATA_FIELDS_W]));
            result_count++;
            rsp_wait = $urandom_range(0, rsp_idle_max);
         end
         if (rsp_wait > 0) begin
            rsp_wait = rsp_wait - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: done, errors");
         $finish;
      end
   end

   task automatic write_length_limit(input logic [CFG_W-1:0] value);
      @(posedge clock);
      csr_data  <= value;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      len_limit = value;
   endtask

   task automatic wait_idle();
      while (pending_bytes.size() != 0 || req_tvalid || expected_tags.size() != 0)
         @(posedge clock);
   endtask

   task automatic queue_frame(input bit drain);
      stream_byte_type sb;
      foreach (frame_bytes[i]) begin
         sb.data  = frame_bytes[i];
         sb.last  = (i == frame_bytes.size() - 1);
         sb.drain = drain && (i == 0);
         pending_bytes.push_back(sb);
      end
      queued_bytes += frame_bytes.size();
   endtask

   // type byte, optional zero pad groups, then the SDNV length
   task automatic append_header(input logic [7:0] kind_code, input logic [31:0] len,
                                input int pad);
      int          groups;
      logic [31:0] grp;
      frame_bytes.push_back(kind_code);
      repeat (pad) frame_bytes.push_back(8'h80);
      groups = 1;
      while (groups < 5 && (len >> (7 * groups)) != 0) groups++;
      for (int i = groups - 1; i >= 0; i--) begin
         grp = len >> (7 * i);
         frame_bytes.push_back({i != 0, grp[6:0]});
      end
   endtask

   task automatic queue_random_buffer(input bit drain);
      int          pick;
      int          len;
      int          top;
      int          pad;
      int          cut;
      logic [7:0]  b;
      frame_bytes.delete();
      pick = $urandom_range(0, 99);
      if (pick < 85) begin
         repeat ($urandom_range(1, 4)) begin
            top = (len_limit < 40) ? int'(len_limit) : 40;
            if ($urandom_range(0, 9) < 8) len = $urandom_range(0, top);
            else len = $urandom_range(0, 40);
            pad = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : 0;
            b = 8'($urandom_range(0, 255));
            append_header(b, len, pad);
            repeat (len) frame_bytes.push_back(8'($urandom_range(0, 255)));
         end
         if (pick >= 65) begin
            cut = $urandom_range(1, frame_bytes.size());
            while (frame_bytes.size() > cut) void'(frame_bytes.pop_back());
         end
      end else if (pick < 93) begin
         b = 8'($urandom_range(0, 255));
         if ($urandom_range(0, 1)) begin
            // length too wide for the accumulator
            frame_bytes.push_back(b);
            b = 8'($urandom_range(16, 127));
            b[7] = 1'b1;
            frame_bytes.push_back(b);
            repeat (3) begin
               b = 8'($urandom_range(0, 255));
               b[7] = 1'b1;
               frame_bytes.push_back(b);
            end
            repeat ($urandom_range(1, 3)) frame_bytes.push_back(8'($urandom_range(0, 255)));
         end else begin
            append_header(b, $urandom, 0);
            repeat ($urandom_range(0, 4)) frame_bytes.push_back(8'($urandom_range(0, 255)));
         end
      end else begin
         repeat ($urandom_range(1, 6)) frame_bytes.push_back(8'($urandom_range(0, 255)));
      end
      queue_frame(drain);
   endtask

   int          req_idle_by_phase[NUM_PHASES] = '{13, 0, 13, 0, 13, 5};
   int          rsp_idle_by_phase[NUM_PHASES] = '{13, 0, 0, 13, 13, 5};
   logic [31:0] limit_by_phase[NUM_PHASES];

   initial begin
      len_limit = '1;
      cur_type  = '0;
      restart_parse();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      write_length_limit('1);

      // zero length, byte extremes, complete item at buffer end
      frame_bytes = '{8'h00, 8'h00, 8'hFF, 8'h02, 8'hAA, 8'h55};
      queue_frame(1'b0);
      // end after type
      frame_bytes = '{8'h7E};
      queue_frame(1'b0);
      // end inside length
      frame_bytes = '{8'h11, 8'h81};
      queue_frame(1'b0);
      // padded length, buffer ends right after it
      frame_bytes = '{8'h22, 8'h80, 8'h03};
      queue_frame(1'b0);
      // end inside value
      frame_bytes = '{8'h33, 8'h04, 8'h01};
      queue_frame(1'b0);
      // too wide, then an ignored byte
      frame_bytes = '{8'h44, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h12};
      queue_frame(1'b0);
      // all-ones length on the last byte
      frame_bytes = '{8'h55, 8'h8F, 8'hFF, 8'hFF, 8'hFF, 8'h7F};
      queue_frame(1'b0);
      wait_idle();

      limit_by_phase[0] = 32'h0;
      limit_by_phase[1] = 32'hFFFF_FFFE;
      limit_by_phase[2] = $urandom_range(1, 12);
      limit_by_phase[3] = $urandom;
      limit_by_phase[4] = 32'hFFFF_FFFF;
      limit_by_phase[5] = $urandom_range(13, 60);

      for (int p = 0; p < NUM_PHASES; p++) begin
         write_length_limit(limit_by_phase[p]);
         req_idle_max = req_idle_by_phase[p];
         rsp_idle_max = rsp_idle_by_phase[p];
         // all-ones length, once ending on the length byte, once one byte later
         frame_bytes = '{8'h66, 8'h8F, 8'hFF, 8'hFF, 8'hFF, 8'h7F};
         queue_frame(p == 2);
         frame_bytes = '{8'h77, 8'h8F, 8'hFF, 8'hFF, 8'hFF, 8'h7F, 8'h00};
         queue_frame(1'b0);
         while (queued_bytes < 30 + (p + 1) * BYTES_PER_PHASE)
            queue_random_buffer($urandom_range(0, 49) == 0);
         wait_idle();
      end

      repeat (8) @(posedge clock);
      if (error_count == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

endmodule
